FILE: hw/rtl/i2cmra_pkg.sv
// Shared constants and types for the I2C master register access block.
package i2cmra_pkg;

    localparam int WRITE_DEPTH_DEFAULT = 16;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [7:0] MSB_MASK          = 8'h80;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_LOAD  = 2'd3;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       done_res;
        logic       status;
    } result_t;

endpackage

FILE: hw/rtl/i2c_master_register_access_top.sv
// I2C master register access: tick-driven bus sequencer with output skid buffer.
// Each tick's result is registered in the output slot, or the skid slot if that is held.
// Throughput: one tick per cycle; the input stalls only while both output slots are full.
// Reset: sequencer returns to idle, write buffer count cleared, ack_timeout back to 250.
// Write buffer contents are not cleared by reset; no clearing pass is run.
module i2c_master_register_access_top
    import i2cmra_pkg::*;
#(
    parameter int WRITE_DEPTH = WRITE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] ack_timeout,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] device_address,
    input  logic [7:0] register_address,
    input  logic [7:0] byte_count,
    input  logic [7:0] data_byte,
    input  logic       sda_sample,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       read_valid,
    output logic [7:0] read_byte,
    output logic       read_last,
    output logic       done_res,
    output logic       status
);

    localparam int PW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam int FW = $clog2(WRITE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST   = PW'(WRITE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL  = FW'(WRITE_DEPTH);
    localparam logic [8:0]    DEPTH_CNT  = 9'(WRITE_DEPTH);

    typedef enum logic [4:0] {
        PH_IDLE, PH_STA1, PH_STA2, PH_TX, PH_ACK_LO, PH_ACK_HI, PH_ACK_POLL,
        PH_RX, PH_MACK_LO, PH_MACK_HI, PH_STO1, PH_STO2
    } phase_t;

    typedef enum logic [1:0] {
        ST_DEV_W, ST_REG, ST_DEV_R, ST_DATA
    } stage_t;

    phase_t          phase_reg, phase_next;
    stage_t          stage_reg, stage_next;
    logic [2:0]      ticks_reg, ticks_next;
    logic [2:0]      bit_reg, bit_next;
    logic [7:0]      shift_reg, shift_next;
    logic [7:0]      left_reg, left_next;
    logic [7:0]      wait_reg, wait_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [PW-1:0]   ptr_reg, ptr_next;
    logic [7:0]      dev_reg, dev_next;
    logic [7:0]      regaddr_reg, regaddr_next;
    logic            is_read_reg, is_read_next;
    logic            err_reg, err_next;
    logic [7:0]      timeout_reg;

    logic [7:0]      mem [WRITE_DEPTH];
    logic [7:0]      rd_data_reg;
    logic            mem_we;

    result_t         res;
    result_t         out_reg, skid_reg;
    logic            out_valid_reg, skid_valid_reg;

    logic            in_accept, out_pop, send_next;
    logic [3:0]      mack_sum;
    logic [7:0]      rx_byte;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_pop   = out_valid_reg && !out_stall;
    assign rx_byte   = {shift_reg[6:0], sda_sample};
    assign mack_sum  = {1'b0, ticks_reg} + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        ticks_next   = ticks_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        wait_next    = wait_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        is_read_next = is_read_reg;
        err_next     = err_reg;
        mem_we       = 1'b0;
        send_next    = 1'b0;

        res            = '0;
        res.scl_level  = 1'b1;
        res.sda_level  = 1'b1;
        res.sda_drive  = 1'b1;
        res.busy_res   = (phase_reg != PH_IDLE);
        res.status     = err_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (func == FUNC_LOAD) begin
                    if (fill_reg < FILL_FULL) begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                end else if (func != FUNC_TICK) begin
                    dev_next     = device_address;
                    regaddr_next = register_address;
                    is_read_next = (func == FUNC_READ);
                    if ((func == FUNC_READ) || ({1'b0, byte_count} <= DEPTH_CNT))
                        left_next = byte_count;
                    else
                        left_next = DEPTH_CNT[7:0];
                    err_next   = 1'b0;
                    ptr_next   = '0;
                    wait_next  = '0;
                    bit_next   = '0;
                    shift_next = device_address;
                    stage_next = ST_DEV_W;
                    phase_next = PH_STA1;
                    ticks_next = '0;
                end
            end
            PH_STA1, PH_STA2:
            begin
                res.sda_level = (phase_reg == PH_STA1);
                if (ticks_reg >= 3'd3) begin
                    phase_next = (phase_reg == PH_STA1) ? PH_STA2 : PH_TX;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_reg + 3'd1;
                end
            end
            PH_TX:
            begin
                res.scl_level = (ticks_reg == 3'd1) || (ticks_reg == 3'd2);
                res.sda_level = ((shift_reg & MSB_MASK) != 8'd0);
                if (ticks_reg >= 3'd4) begin
                    ticks_next = '0;
                    shift_next = {shift_reg[6:0], 1'b0};
                    if (bit_reg >= 3'd7) begin
                        bit_next   = '0;
                        phase_next = PH_ACK_LO;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end else begin
                    ticks_next = ticks_reg + 3'd1;
                end
            end
            PH_ACK_LO:
            begin
                res.scl_level = 1'b0;
                res.sda_drive = 1'b0;
                phase_next    = PH_ACK_HI;
                ticks_next    = '0;
            end
            PH_ACK_HI:
            begin
                res.sda_drive = 1'b0;
                phase_next    = PH_ACK_POLL;
                ticks_next    = '0;
            end
            PH_ACK_POLL:
            begin
                res.sda_drive = 1'b0;
                if (!sda_sample) begin
                    wait_next = '0;
                    case (stage_reg)
                        ST_DEV_W:
                        begin
                            shift_next = regaddr_reg;
                            stage_next = ST_REG;
                            bit_next   = '0;
                            phase_next = PH_TX;
                            ticks_next = '0;
                        end
                        ST_REG:
                        begin
                            if (is_read_reg) begin
                                shift_next = dev_reg | 8'd1;
                                stage_next = ST_DEV_R;
                                phase_next = PH_STA1;
                                ticks_next = '0;
                            end else begin
                                send_next = 1'b1;
                            end
                        end
                        ST_DEV_R:
                        begin
                            ticks_next = '0;
                            if (left_reg != 8'd0) begin
                                shift_next = '0;
                                bit_next   = '0;
                                phase_next = PH_RX;
                            end else begin
                                phase_next = PH_STO1;
                            end
                        end
                        default:
                        begin
                            send_next = 1'b1;
                        end
                    endcase
                end else if (wait_reg >= timeout_reg) begin
                    wait_next  = '0;
                    err_next   = 1'b1;
                    phase_next = PH_STO1;
                    ticks_next = '0;
                end else begin
                    wait_next = wait_reg + 8'd1;
                end
            end
            PH_RX:
            begin
                res.scl_level = (ticks_reg >= 3'd2);
                res.sda_drive = 1'b0;
                if (ticks_reg == 3'd3) begin
                    shift_next = rx_byte;
                    if (bit_reg >= 3'd7) begin
                        res.read_valid = 1'b1;
                        res.read_byte  = rx_byte;
                        res.read_last  = (left_reg <= 8'd1);
                    end
                end
                if (ticks_reg >= 3'd4) begin
                    ticks_next = '0;
                    if (bit_reg >= 3'd7) begin
                        bit_next = '0;
                        if (left_reg != 8'd0)
                            left_next = left_reg - 8'd1;
                        phase_next = PH_MACK_LO;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end else begin
                    ticks_next = ticks_reg + 3'd1;
                end
            end
            PH_MACK_LO:
            begin
                res.scl_level = 1'b0;
                res.sda_level = (left_reg == 8'd0);
                phase_next    = PH_MACK_HI;
                ticks_next    = '0;
            end
            PH_MACK_HI:
            begin
                res.sda_level = (left_reg == 8'd0);
                if (mack_sum >= ((left_reg != 8'd0) ? 4'd2 : 4'd1)) begin
                    shift_next = '0;
                    phase_next = (left_reg != 8'd0) ? PH_RX : PH_STO1;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_reg + 3'd1;
                end
            end
            PH_STO1:
            begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
                if (ticks_reg >= 3'd3) begin
                    phase_next = PH_STO2;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_reg + 3'd1;
                end
            end
            PH_STO2:
            begin
                if (ticks_reg >= 3'd3) begin
                    res.done_res = 1'b1;
                    if (!is_read_reg)
                        fill_next = '0;
                    ptr_next   = '0;
                    phase_next = PH_IDLE;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_reg + 3'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase

        if (send_next) begin
            ticks_next = '0;
            if (left_reg != 8'd0) begin
                shift_next = rd_data_reg;
                ptr_next   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PW'(1);
                left_next  = left_reg - 8'd1;
                stage_next = ST_DATA;
                bit_next   = '0;
                phase_next = PH_TX;
            end else begin
                phase_next = PH_STO1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            stage_reg   <= ST_DEV_W;
            ticks_reg   <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            left_reg    <= '0;
            wait_reg    <= '0;
            fill_reg    <= '0;
            ptr_reg     <= '0;
            dev_reg     <= '0;
            regaddr_reg <= '0;
            is_read_reg <= 1'b0;
            err_reg     <= 1'b0;
            timeout_reg <= ACK_TIMEOUT_RESET;
        end else begin
            if (cfg_valid && cfg_ready)
                timeout_reg <= ack_timeout;
            if (in_accept) begin
                phase_reg   <= phase_next;
                stage_reg   <= stage_next;
                ticks_reg   <= ticks_next;
                bit_reg     <= bit_next;
                shift_reg   <= shift_next;
                left_reg    <= left_next;
                wait_reg    <= wait_next;
                fill_reg    <= fill_next;
                ptr_reg     <= ptr_next;
                dev_reg     <= dev_next;
                regaddr_reg <= regaddr_next;
                is_read_reg <= is_read_next;
                err_reg     <= err_next;
            end
        end
    end

    // write buffer; read data is registered from the entry at the pointer
    always_ff @(posedge clk)
    begin
        if (in_accept && mem_we)
            mem[fill_reg[PW-1:0]] <= data_byte;
        rd_data_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                if (!out_valid_reg || out_pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_pop && skid_valid_reg)
            out_reg <= skid_reg;
        if (in_accept) begin
            if (!out_valid_reg || out_pop)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = out_reg.scl_level;
    assign sda_level  = out_reg.sda_level;
    assign sda_drive  = out_reg.sda_drive;
    assign busy_res   = out_reg.busy_res;
    assign read_valid = out_reg.read_valid;
    assign read_byte  = out_reg.read_byte;
    assign read_last  = out_reg.read_last;
    assign done_res   = out_reg.done_res;
    assign status     = out_reg.status;

    a_rx_bus_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_valid) |-> (scl_level && !sda_drive))
        else $error("received byte presented without SCL high and SDA released");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> busy_res)
        else $error("transaction done reported while idle");

    a_wait_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_ACK_POLL) |-> (wait_reg == 8'd0))
        else $error("acknowledge wait count left nonzero outside polling");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("write buffer fill beyond depth");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output slot empty");

endmodule

FILE: test/tb_i2c_master_register_access_top.sv
// Self-checking testbench: bus-tick stimulus and per-tick pin predictions for the I2C register master.
module tb_i2c_master_register_access_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmra_pkg::*;

    localparam int DEPTH       = WRITE_DEPTH_DEFAULT;
    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_START_HI,
        BUS_START_LO,
        BUS_SEND,
        BUS_ACK_LO,
        BUS_ACK_HI,
        BUS_ACK_POLL,
        BUS_RECV,
        BUS_MACK_LO,
        BUS_MACK_HI,
        BUS_STOP_LO,
        BUS_STOP_HI
    } bus_phase_t;

    typedef enum logic [1:0] {
        SEND_DEV_WR,
        SEND_REG,
        SEND_DEV_RD,
        SEND_DATA
    } send_stage_t;

    typedef struct packed {
        logic [7:0]       ack_limit;
        bus_phase_t       phase;
        logic [2:0]       ticks;
        logic [2:0]       bit_idx;
        logic [7:0]       shreg;
        logic [7:0]       bytes_left;
        logic [7:0]       ack_wait;
        logic [15:0][7:0] wbuf;
        logic [4:0]       fill;
        logic [3:0]       rd_ptr;
        logic [7:0]       dev;
        logic [7:0]       reg_addr;
        logic             rd_mode;
        logic             err;
        send_stage_t      stage;
    } bus_model_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] dev;
        logic [7:0] reg_addr;
        logic [7:0] count;
        logic [7:0] data;
        logic       sda;
    } tick_t;

    logic       clk;
    logic       rst_n            = 1'b0;
    logic       cfg_valid        = 1'b0;
    logic       cfg_ready;
    logic [7:0] ack_timeout      = ACK_TIMEOUT_RESET;
    logic       in_valid         = 1'b0;
    logic       in_stall;
    logic [1:0] func             = FUNC_TICK;
    logic [7:0] device_address   = 8'h00;
    logic [7:0] register_address = 8'h00;
    logic [7:0] byte_count       = 8'h00;
    logic [7:0] data_byte        = 8'h00;
    logic       sda_sample       = 1'b1;
    logic       out_valid;
    logic       out_stall        = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
    logic       done_res;
    logic       status;

    bus_model_t  bus_mirror;
    bus_model_t  plan_bus;
    tick_t       tick_q[$];
    result_t     expected_pins_q[$];
    int          ticks_planned = 0;
    int          ticks_taken   = 0;
    int          mismatches    = 0;
    int          cycles        = 0;
    int          holds_asked   = 0;
    int          holds_granted = 0;
    int          hold_left     = 0;
    int unsigned in_gap        = 0;
    int unsigned sink_wait     = 0;
    bit          feed_calm     = 1'b0;
    bit          sink_calm     = 1'b0;
    logic        in_took       = 1'b0;
    logic        out_took      = 1'b0;

    i2c_master_register_access_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .ack_timeout      (ack_timeout),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .device_address   (device_address),
        .register_address (register_address),
        .byte_count       (byte_count),
        .data_byte        (data_byte),
        .sda_sample       (sda_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .scl_level        (scl_level),
        .sda_level        (sda_level),
        .sda_drive        (sda_drive),
        .busy_res         (busy_res),
        .read_valid       (read_valid),
        .read_byte        (read_byte),
        .read_last        (read_last),
        .done_res         (done_res),
        .status           (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bus_model_t bus_reset();
        bus_model_t m;
        m           = '0;
        m.ack_limit = ACK_TIMEOUT_RESET;
        m.phase     = BUS_IDLE;
        m.stage     = SEND_DEV_WR;
        return m;
    endfunction

    function automatic void enter(inout bus_model_t m, input bus_phase_t p);
        m.phase = p;
        m.ticks = '0;
    endfunction

    function automatic void next_data_or_stop(inout bus_model_t m);
        if (m.bytes_left != 0)
        begin
            m.shreg   = m.wbuf[m.rd_ptr];
            m.rd_ptr  = m.rd_ptr + 4'd1;
            m.bytes_left--;
            m.stage   = SEND_DATA;
            m.bit_idx = '0;
            enter(m, BUS_SEND);
        end
        else
        begin
            enter(m, BUS_STOP_LO);
        end
    endfunction

    // One bus tick: pins reflect the phase at the start of the tick.
    function automatic void bus_tick(inout bus_model_t m, input tick_t t, output result_t r);
        r           = '0;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        r.sda_drive = 1'b1;
        r.busy_res  = (m.phase != BUS_IDLE);
        r.status    = m.err;
        case (m.phase)
            BUS_IDLE:
            begin
                if (t.func == FUNC_LOAD)
                begin
                    if (m.fill < 5'(DEPTH))
                    begin
                        m.wbuf[m.fill[3:0]] = t.data;
                        m.fill++;
                    end
                end
                else if (t.func != FUNC_TICK)
                begin
                    m.dev        = t.dev;
                    m.reg_addr   = t.reg_addr;
                    m.rd_mode    = (t.func == FUNC_READ);
                    m.bytes_left = (m.rd_mode || t.count <= 8'(DEPTH)) ? t.count : 8'(DEPTH);
                    m.err        = 1'b0;
                    m.rd_ptr     = '0;
                    m.ack_wait   = '0;
                    m.bit_idx    = '0;
                    m.shreg      = t.dev;
                    m.stage      = SEND_DEV_WR;
                    enter(m, BUS_START_HI);
                end
            end
            BUS_START_HI, BUS_START_LO:
            begin
                r.sda_level = (m.phase == BUS_START_HI);
                if (m.ticks >= 3'd3)
                    enter(m, m.phase == BUS_START_HI ? BUS_START_LO : BUS_SEND);
                else
                    m.ticks++;
            end
            BUS_SEND:
            begin
                r.scl_level = (m.ticks == 3'd1 || m.ticks == 3'd2);
                r.sda_level = m.shreg[7];
                if (m.ticks >= 3'd4)
                begin
                    m.ticks = '0;
                    m.shreg = m.shreg << 1;
                    if (m.bit_idx >= 3'd7)
                    begin
                        m.bit_idx = '0;
                        enter(m, BUS_ACK_LO);
                    end
                    else
                    begin
                        m.bit_idx++;
                    end
                end
                else
                begin
                    m.ticks++;
                end
            end
            BUS_ACK_LO:
            begin
                r.scl_level = 1'b0;
                r.sda_drive = 1'b0;
                enter(m, BUS_ACK_HI);
            end
            BUS_ACK_HI:
            begin
                r.sda_drive = 1'b0;
                enter(m, BUS_ACK_POLL);
            end
            BUS_ACK_POLL:
            begin
                r.sda_drive = 1'b0;
                if (!t.sda)
                begin
                    m.ack_wait = '0;
                    case (m.stage)
                        SEND_DEV_WR:
                        begin
                            m.shreg   = m.reg_addr;
                            m.stage   = SEND_REG;
                            m.bit_idx = '0;
                            enter(m, BUS_SEND);
                        end
                        SEND_REG:
                        begin
                            if (m.rd_mode)
                            begin
                                m.shreg = m.dev | 8'h01;
                                m.stage = SEND_DEV_RD;
                                enter(m, BUS_START_HI);
                            end
                            else
                            begin
                                next_data_or_stop(m);
                            end
                        end
                        SEND_DEV_RD:
                        begin
                            if (m.bytes_left != 0)
                            begin
                                m.shreg   = '0;
                                m.bit_idx = '0;
                                enter(m, BUS_RECV);
                            end
                            else
                            begin
                                enter(m, BUS_STOP_LO);
                            end
                        end
                        default:
                            next_data_or_stop(m);
                    endcase
                end
                else if (m.ack_wait >= m.ack_limit)
                begin
                    m.ack_wait = '0;
                    m.err      = 1'b1;
                    enter(m, BUS_STOP_LO);
                end
                else
                begin
                    m.ack_wait++;
                end
            end
            BUS_RECV:
            begin
                r.scl_level = (m.ticks >= 3'd2);
                r.sda_drive = 1'b0;
                if (m.ticks == 3'd3)
                begin
                    m.shreg = {m.shreg[6:0], t.sda};
                    if (m.bit_idx >= 3'd7)
                    begin
                        r.read_valid = 1'b1;
                        r.read_byte  = m.shreg;
                        r.read_last  = (m.bytes_left <= 8'd1);
                    end
                end
                if (m.ticks >= 3'd4)
                begin
                    m.ticks = '0;
                    if (m.bit_idx >= 3'd7)
                    begin
                        m.bit_idx = '0;
                        if (m.bytes_left != 0)
                            m.bytes_left--;
                        enter(m, BUS_MACK_LO);
                    end
                    else
                    begin
                        m.bit_idx++;
                    end
                end
                else
                begin
                    m.ticks++;
                end
            end
            BUS_MACK_LO:
            begin
                r.scl_level = 1'b0;
                r.sda_level = (m.bytes_left == 0);
                enter(m, BUS_MACK_HI);
            end
            BUS_MACK_HI:
            begin
                r.sda_level = (m.bytes_left == 0);
                if (32'(m.ticks) + 1 >= (m.bytes_left != 0 ? 2 : 1))
                begin
                    m.shreg = '0;
                    enter(m, m.bytes_left != 0 ? BUS_RECV : BUS_STOP_LO);
                end
                else
                begin
                    m.ticks++;
                end
            end
            BUS_STOP_LO:
            begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b0;
                if (m.ticks >= 3'd3)
                    enter(m, BUS_STOP_HI);
                else
                    m.ticks++;
            end
            BUS_STOP_HI:
            begin
                if (m.ticks >= 3'd3)
                begin
                    r.done_res = 1'b1;
                    if (!m.rd_mode)
                        m.fill = '0;
                    m.rd_ptr = '0;
                    enter(m, BUS_IDLE);
                end
                else
                begin
                    m.ticks++;
                end
            end
            default:
                enter(m, BUS_IDLE);
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.func     = 2'($urandom);
        t.dev      = 8'($urandom);
        t.reg_addr = 8'($urandom);
        t.count    = 8'($urandom);
        t.data     = 8'($urandom);
        t.sda      = 1'($urandom);
        return t;
    endfunction

    task automatic plan_tick(input tick_t t);
        result_t unused;
        bus_tick(plan_bus, t, unused);
        tick_q.push_back(t);
        ticks_planned++;
    endtask

    task automatic plan_load(input logic [7:0] value);
        tick_t t;
        t      = random_tick();
        t.func = FUNC_LOAD;
        t.data = value;
        plan_tick(t);
    endtask

    task automatic plan_idle_tick();
        tick_t t;
        t      = random_tick();
        t.func = FUNC_TICK;
        plan_tick(t);
    endtask

    // Command tick followed by bus ticks until stop; nack holds SDA high on every ack poll.
    task automatic plan_transfer(input logic [1:0] op, input logic [7:0] dev,
                                 input logic [7:0] reg_addr, input logic [7:0] count,
                                 input bit nack);
        tick_t t;
        t          = random_tick();
        t.func     = op;
        t.dev      = dev;
        t.reg_addr = reg_addr;
        t.count    = count;
        plan_tick(t);
        while (plan_bus.phase != BUS_IDLE)
        begin
            t = random_tick();
            if (plan_bus.phase == BUS_ACK_POLL)
                t.sda = nack ? 1'b1 : 1'($urandom_range(0, 3) == 0);
            plan_tick(t);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (ticks_taken != ticks_planned || expected_pins_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_ack_limit(input logic [7:0] value);
        @(negedge clk);
        cfg_valid   <= 1'b1;
        ack_timeout <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bus_mirror.ack_limit = value;
        plan_bus.ack_limit   = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_pin(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin : feed
        tick_t t;
        logic  show;
        if (rst_n)
        begin
            show = in_valid && !in_took;
            if (!show)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                end
                else if (tick_q.size() > 0)
                begin
                    t                = tick_q.pop_front();
                    func             <= t.func;
                    device_address   <= t.dev;
                    register_address <= t.reg_addr;
                    byte_count       <= t.count;
                    data_byte        <= t.data;
                    sda_sample       <= t.sda;
                    show             = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        feed_calm = !feed_calm;
                    in_gap = feed_calm ? 0 : $urandom_range(0, 5);
                end
            end
            in_valid <= show;
        end
    end

    always @(negedge clk)
    begin : sink
        if (out_took)
        begin
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            sink_wait = sink_calm ? 0 : $urandom_range(0, 5);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (holds_granted != holds_asked)
        begin
            holds_granted++;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (sink_wait > 0)
        begin
            sink_wait--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        tick_t   t;
        in_took  <= in_valid && !in_stall;
        out_took <= out_valid && !out_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {scl_level, sda_level, sda_drive, busy_res, read_valid, read_byte,
                       read_last, done_res, status};
                if (expected_pins_q.size() == 0)
                begin
                    $error("result transaction with no tick pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_pins_q.pop_front();
                    compare_pin("scl_level", 8'(want.scl_level), 8'(got.scl_level));
                    compare_pin("sda_level", 8'(want.sda_level), 8'(got.sda_level));
                    compare_pin("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
                    compare_pin("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    compare_pin("read_valid", 8'(want.read_valid), 8'(got.read_valid));
                    compare_pin("read_byte", want.read_byte, got.read_byte);
                    compare_pin("read_last", 8'(want.read_last), 8'(got.read_last));
                    compare_pin("done_res", 8'(want.done_res), 8'(got.done_res));
                    compare_pin("status", 8'(want.status), 8'(got.status));
                end
            end
            if (in_valid && !in_stall)
            begin
                t = {func, device_address, register_address, byte_count, data_byte, sda_sample};
                bus_tick(bus_mirror, t, want);
                expected_pins_q.push_back(want);
                ticks_taken++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int k;
        bus_mirror = bus_reset();
        plan_bus   = bus_reset();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty transfers, full buffer, short write and read
        plan_idle_tick();
        plan_transfer(FUNC_WRITE, 8'h00, 8'h00, 8'd0, 1'b0);
        plan_transfer(FUNC_READ, 8'hFF, 8'hFF, 8'd0, 1'b0);
        plan_load(8'h00);
        plan_load(8'hFF);
        plan_load(8'hA5);
        plan_load(8'h5A);
        for (k = 4; k < DEPTH; k++)
            plan_load(8'($urandom));
        plan_load(8'h3C);
        plan_transfer(FUNC_WRITE, 8'h5A, 8'h80, 8'd2, 1'b0);
        plan_transfer(FUNC_READ, 8'hA0, 8'h01, 8'd2, 1'b0);
        holds_asked++;
        wait_drained();

        // acknowledge timeouts at short limits
        set_ack_limit(8'd1);
        plan_transfer(FUNC_READ, 8'h3C, 8'h10, 8'd4, 1'b1);
        wait_drained();

        set_ack_limit(8'd3);
        plan_transfer(FUNC_WRITE, 8'hC3, 8'h20, 8'd4, 1'b1);
        holds_asked++;
        wait_drained();

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
